// ----- rtl/sckq_pkg.sv -----
// Package for the scan code to ASCII key queue: sizes, cell control type, code translation.
`timescale 1ns / 1ps
`default_nettype none
package sckq_pkg;

  localparam int BUFFER_SIZE = 256;
  localparam int QCAP        = BUFFER_SIZE - 1;
  localparam int CNT_W       = $clog2(BUFFER_SIZE);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [6:0]       char_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam logic [7:0] ROW_TOP [10] = '{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p"};
  localparam logic [7:0] ROW_MID [9]  = '{"a", "s", "d", "f", "g", "h", "j", "k", "l"};
  localparam logic [7:0] ROW_BOT [7]  = '{"z", "x", "c", "v", "b", "n", "m"};

  function automatic char_t translate_code(input logic [7:0] code);
    logic [7:0] ofs;
    char_t      ch;
    ofs = 8'h00;
    ch  = 7'h00;
    if (code == 8'h1C) begin
      ch = 7'h0A;
    end else if (code == 8'h39) begin
      ch = 7'(8'(" "));
    end else if (code == 8'h0E) begin
      ch = 7'h0D;
    end else if (code == 8'h34) begin
      ch = 7'(8'("."));
    end else if (code == 8'h35) begin
      ch = 7'(8'("/"));
    end else if (code == 8'h0B) begin
      ch = 7'(8'("0"));
    end else if (code >= 8'h02 && code <= 8'h0A) begin
      ofs = code - 8'h02;
      ch  = 7'(8'("1") + ofs);
    end else if (code >= 8'h10 && code <= 8'h19) begin
      ofs = code - 8'h10;
      ch  = ROW_TOP[ofs[3:0]][6:0];
    end else if (code >= 8'h1E && code <= 8'h26) begin
      ofs = code - 8'h1E;
      ch  = ROW_MID[ofs[3:0]][6:0];
    end else if (code >= 8'h2C && code <= 8'h32) begin
      ofs = code - 8'h2C;
      ch  = ROW_BOT[ofs[2:0]][6:0];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sckq_if.sv -----
// Handshake interfaces for the key queue request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface sckq_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] scan_code;
  modport source (output valid, func, scan_code, input ready);
  modport sink   (input valid, func, scan_code, output ready);
endinterface

interface sckq_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] key_char;
  logic       dropped;
  logic [7:0] fill_level;
  modport source (output valid, key_char, dropped, fill_level, input ready);
  modport sink   (input valid, key_char, dropped, fill_level, output ready);
endinterface
`default_nettype wire

// ----- rtl/sckq_cell.sv -----
// One queue cell: holds a character, loads a push or takes its neighbor's on a pop.
`timescale 1ns / 1ps
`default_nettype none
module sckq_cell
  import sckq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire char_t      push_char,
  input  wire char_t      next_char,
  output char_t           char_o
);

  char_t char_r;
  char_t char_nxt;

  always_comb begin
    char_nxt = char_r;
    if (ctrl.load) begin
      char_nxt = push_char;
    end else if (ctrl.shift) begin
      char_nxt = next_char;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_o = char_r;

endmodule
`default_nettype wire

// ----- rtl/scancode_to_ascii_key_queue.sv -----
// Top level of the scan code to ASCII key queue.
// Takes one item per clock: a push translates a set-1 scan code to ASCII and
// appends it to a queue of QCAP (BUFFER_SIZE-1) characters, a read pops the
// oldest character (0 if empty). The queue is a row of QCAP cells; the head
// sits in cell 0, a read shifts every cell one place toward the head in the
// same cycle, and a push loads the cell indexed by the fill count. Each item
// gives one result in the cycle after acceptance through an output register, so
// a new item is taken every cycle as long as the result side keeps up.
`timescale 1ns / 1ps
`default_nettype none
module scancode_to_ascii_key_queue
  import sckq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  sckq_in_if.sink     in_ch,
  sckq_out_if.source  out_ch
);

  count_t     count_r;
  count_t     count_nxt;
  logic       out_valid_r;
  char_t      key_char_r;
  char_t      key_char_nxt;
  logic       dropped_r;
  logic       dropped_nxt;
  logic       accept;
  logic       is_push;
  logic       is_read;
  logic       full;
  logic       empty;
  char_t      push_char;
  char_t      cell_q [QCAP];
  cell_ctrl_t cell_ctrl [QCAP];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == count_t'(QCAP));
  assign empty       = (count_r == '0);
  assign is_push     = accept && (in_ch.func == FUNC_PUSH) && !full;
  assign is_read     = accept && (in_ch.func == FUNC_READ) && !empty;
  assign push_char   = translate_code(in_ch.scan_code);

  for (genvar i = 0; i < QCAP; i++) begin : g_cell
    char_t nbr;
    assign cell_ctrl[i].load  = is_push && (count_r == count_t'(i));
    assign cell_ctrl[i].shift = is_read;
    if (i == QCAP - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    sckq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .push_char (push_char),
      .next_char (nbr),
      .char_o    (cell_q[i])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    key_char_nxt = '0;
    dropped_nxt  = 1'b0;
    if (is_push) begin
      count_nxt = count_r + count_t'(1);
    end else if (is_read) begin
      count_nxt    = count_r - count_t'(1);
      key_char_nxt = cell_q[0];
    end
    if (accept && (in_ch.func == FUNC_PUSH) && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      key_char_r <= key_char_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.key_char   = key_char_r;
  assign out_ch.dropped    = dropped_r;
  assign out_ch.fill_level = 8'(count_r);

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(QCAP))
    else $error("fill count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dropped_r) |-> full)
    else $error("drop flagged while queue not full");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.func == FUNC_READ) && empty) |=> (key_char_r == '0 && count_r == '0))
    else $error("read of empty queue returned data or changed count");
`endif

endmodule
`default_nettype wire

// ----- dv/sckq_key_checker.sv -----
// Checker for the key queue: models the translation and the FIFO, compares every result item.
`timescale 1ns / 1ps
module sckq_key_checker
  import sckq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sckq_in_if   in_mon,
  sckq_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   push_count,
  output int   drop_count,
  output int   read_count,
  output int   empty_reads,
  output int   peak_fill
);

  typedef struct packed {
    char_t      key_char;
    logic       dropped;
    logic [7:0] fill_level;
  } key_result_t;

  char_t       held_keys[$];
  key_result_t awaited_results[$];

  function automatic char_t ascii_of_code(input logic [7:0] code);
    string top_row;
    string mid_row;
    string bot_row;
    char_t ch;
    top_row = "qwertyuiop";
    mid_row = "asdfghjkl";
    bot_row = "zxcvbnm";
    ch      = '0;
    if (code == 8'h1C) begin
      ch = 7'h0A;
    end else if (code == 8'h39) begin
      ch = 7'h20;
    end else if (code == 8'h0E) begin
      ch = 7'h0D;
    end else if (code == 8'h34) begin
      ch = 7'h2E;
    end else if (code == 8'h35) begin
      ch = 7'h2F;
    end else if (code == 8'h0B) begin
      ch = 7'h30;
    end else if (code >= 8'h02 && code <= 8'h0A) begin
      ch = 7'(code) + 7'h2F;
    end else if (code >= 8'h10 && code <= 8'h19) begin
      ch = 7'(top_row[int'(code) - 'h10]);
    end else if (code >= 8'h1E && code <= 8'h26) begin
      ch = 7'(mid_row[int'(code) - 'h1E]);
    end else if (code >= 8'h2C && code <= 8'h32) begin
      ch = 7'(bot_row[int'(code) - 'h2C]);
    end
    return ch;
  endfunction

  initial begin
    fail_count  = 0;
    push_count  = 0;
    drop_count  = 0;
    read_count  = 0;
    empty_reads = 0;
    peak_fill   = 0;
    pending     = 0;
  end

  always @(posedge clk) begin
    key_result_t want;
    key_result_t seen;
    if (!rst_n) begin
      held_keys.delete();
      awaited_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        want = '0;
        if (in_mon.func == FUNC_PUSH) begin
          push_count++;
          if (held_keys.size() >= QCAP) begin
            want.dropped = 1'b1;
            drop_count++;
          end else begin
            held_keys.push_back(ascii_of_code(in_mon.scan_code));
          end
        end else begin
          read_count++;
          if (held_keys.size() == 0) begin
            empty_reads++;
          end else begin
            want.key_char = held_keys.pop_front();
          end
        end
        want.fill_level = 8'(held_keys.size());
        if (held_keys.size() > peak_fill) begin
          peak_fill = held_keys.size();
        end
        awaited_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.key_char   = out_mon.key_char;
        seen.dropped    = out_mon.dropped;
        seen.fill_level = out_mon.fill_level;
        if (awaited_results.size() == 0) begin
          $error("result item with none outstanding: key_char %0h dropped %0b fill_level %0d",
                 seen.key_char, seen.dropped, seen.fill_level);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.key_char !== want.key_char) begin
            $error("key_char: expected %0h, actual %0h", want.key_char, seen.key_char);
            fail_count++;
          end
          if (seen.dropped !== want.dropped) begin
            $error("dropped: expected %0b, actual %0b", want.dropped, seen.dropped);
            fail_count++;
          end
          if (seen.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, actual %0d", want.fill_level, seen.fill_level);
            fail_count++;
          end
        end
      end
    end
    pending <= awaited_results.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the key queue testbench: clock, reset, item and stall generation, watchdog, verdict.
`timescale 1ns / 1ps
module tb_top;
  import sckq_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sckq_in_if  key_in ();
  sckq_out_if key_out ();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int items_sent     = 0;

  int fail_count;
  int pending;
  int push_count;
  int drop_count;
  int read_count;
  int empty_reads;
  int peak_fill;

  always #6 clk = ~clk;

  scancode_to_ascii_key_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (key_in),
    .out_ch (key_out)
  );

  sckq_key_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (key_in),
    .out_mon     (key_out),
    .fail_count  (fail_count),
    .pending     (pending),
    .push_count  (push_count),
    .drop_count  (drop_count),
    .read_count  (read_count),
    .empty_reads (empty_reads),
    .peak_fill   (peak_fill)
  );

  // receiver: random stalls plus one long hold-off
  initial begin
    key_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        key_out.ready <= 1'b0;
      end else begin
        key_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (key_in.valid && key_in.ready) || (key_out.valid && key_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic fn, input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      key_in.valid <= 1'b0;
      @(posedge clk);
    end
    key_in.valid     <= 1'b1;
    key_in.func      <= fn;
    key_in.scan_code <= code;
    @(posedge clk);
    while (!key_in.ready) @(posedge clk);
    items_sent++;
  endtask

  // mostly mapped keys, the rest releases and arbitrary bytes
  function automatic logic [7:0] pick_scan_code();
    logic [7:0] code;
    case ($urandom_range(5))
      0: code = 8'($urandom_range(8'h0E, 8'h02));
      1: code = 8'($urandom_range(8'h1C, 8'h10));
      2: code = 8'($urandom_range(8'h26, 8'h1E));
      3: code = 8'($urandom_range(8'h35, 8'h2C));
      4: code = ($urandom_range(1) == 0) ? 8'h39 : (8'($urandom_range(8'h39, 8'h01)) | 8'h80);
      default: code = 8'($urandom);
    endcase
    return code;
  endfunction

  initial begin
    logic [7:0] opening_codes [20] = '{8'h1C, 8'h39, 8'h0E, 8'h34, 8'h35, 8'h0B, 8'h02,
                                       8'h0A, 8'h10, 8'h19, 8'h1A, 8'h1B, 8'h1E, 8'h26,
                                       8'h2C, 8'h32, 8'h00, 8'hFF, 8'h9C, 8'h80};
    int send_mix [4] = '{0, 60, 0, 7};
    int recv_mix [4] = '{0, 0, 60, 7};
    int push_bias [8] = '{30, 70, 50, 65, 40, 55, 45, 60};

    key_in.valid     = 1'b0;
    key_in.func      = FUNC_PUSH;
    key_in.scan_code = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, every translated group and its edges, unmapped codes
    send_item(FUNC_READ, 8'h00);
    send_item(FUNC_READ, 8'hFF);
    foreach (opening_codes[i]) send_item(FUNC_PUSH, opening_codes[i]);
    repeat (3) send_item(FUNC_READ, 8'($urandom));

    for (int p = 0; p < 8; p++) begin
      send_idle_pct  = send_mix[p % 4];
      recv_stall_pct = recv_mix[p % 4];
      repeat (95) begin
        if ($urandom_range(99) < push_bias[p]) begin
          send_item(FUNC_PUSH, pick_scan_code());
        end else begin
          send_item(FUNC_READ, 8'($urandom));
        end
      end
    end

    // fill past capacity under a long output hold-off, then drain past empty
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = LONG_HOLD;
    repeat (QCAP + 12) send_item(FUNC_PUSH, pick_scan_code());
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    repeat (QCAP + 4) send_item(FUNC_READ, 8'($urandom));

    key_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d items, %0d pushes (%0d dropped at full), %0d reads (%0d on empty).",
             items_sent, push_count, drop_count, read_count, empty_reads);
    $display("Peak fill %0d of %0d; mapped keys, releases and random bytes under four idling mixes and a hold-off.",
             peak_fill, QCAP);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
